// ----- hw/rtl/triggered_interval_timer_bank_assert.svh -----
// Assertion macros for the triggered interval timer bank.
`ifndef TRIGGERED_INTERVAL_TIMER_BANK_ASSERT_SVH
`define TRIGGERED_INTERVAL_TIMER_BANK_ASSERT_SVH

`ifndef SYNTHESIS
// Property must hold at every clock edge outside reset.
`define TIB_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Condition must never be true outside reset.
`define TIB_NEVER(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define TIB_ASSERT(lbl, clk, rst_n, prop, msg)
`define TIB_NEVER(lbl, clk, rst_n, cond, msg)
`endif

`endif

// ----- hw/rtl/tib_pkg.sv -----
// Shared types, codes and helpers of the triggered interval timer bank.
`default_nettype none

package tib_pkg;

	localparam int unsigned NUM_CHANNELS_DEF = 40;
	localparam int unsigned CNT_W            = 32;
	localparam int unsigned CH_W             = 6;
	localparam int unsigned TM_W             = 3;

	// item kinds
	localparam logic MODE_TICK = 1'b0;
	localparam logic MODE_POLL = 1'b1;

	// trigger modes; codes four to seven are inactive
	localparam logic [TM_W-1:0] TM_LOW  = 3'd0;
	localparam logic [TM_W-1:0] TM_HIGH = 3'd1;
	localparam logic [TM_W-1:0] TM_RISE = 3'd2;
	localparam logic [TM_W-1:0] TM_FALL = 3'd3;

	typedef struct packed {
		logic [CNT_W-1:0] cnt;
		logic [TM_W-1:0]  tmode;
		logic             lvl;
		logic             armed;
	} tib_entry_t;

	typedef struct packed {
		logic [CNT_W-1:0] cnt;
		logic             armed;
	} tib_pre_t;

	typedef struct packed {
		logic             start;
		logic [CNT_W-1:0] dividend;
		logic [CNT_W-1:0] divisor;
	} tib_div_req_t;

	typedef struct packed {
		logic             busy;
		logic             done;
		logic [CNT_W-1:0] rem;
	} tib_div_rsp_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_TICK,
		S_TICK_END,
		S_POLL_RD,
		S_POLL_EVAL,
		S_POLL_DIV,
		S_DONE
	} tib_state_t;

	// Trigger evaluation ahead of the period check.
	function automatic tib_pre_t trig_pre(input tib_entry_t e, input logic [TM_W-1:0] tm,
			input logic lvl);
		tib_pre_t p;
		logic     hit;
		p.cnt   = e.cnt;
		p.armed = e.armed;
		hit     = 1'b0;
		unique case (tm)
			TM_LOW: begin
				if (e.tmode != TM_LOW || lvl != 1'b0) p.cnt = '0;
			end
			TM_HIGH: begin
				if (e.tmode != TM_HIGH || lvl != 1'b1) p.cnt = '0;
			end
			TM_RISE, TM_FALL: begin
				if (e.tmode != tm) begin
					p.cnt   = '0;
					p.armed = 1'b0;
				end
				if (!p.armed) p.cnt = '0;
				if (tm == TM_RISE) hit = lvl && !e.lvl;
				else               hit = !lvl && e.lvl;
				if (hit) p.armed = 1'b1;
			end
			default: begin
				p.cnt   = e.cnt;
				p.armed = e.armed;
			end
		endcase
		return p;
	endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/triggered_interval_timer_bank.sv -----
// Top level of the triggered interval timer bank: sequencer, trigger datapath, result register.
`default_nettype none

// A bank of NUM_CHANNELS interval timers whose state (count, last trigger
// mode, last level, arming) sits in one synchronous memory. One word in,
// one word out, always. A tick word sweeps the memory one channel per
// cycle (read, saturating increment, write back in the next cycle) and
// occupies the block until the last channel is written back. A poll
// word reads its channel, evaluates the trigger and writes back; when
// the count has reached the period the remainder unit runs one bit per
// cycle before the write-back. Polls of a channel past the bank and
// polls with trigger modes four to seven never start the remainder unit.
// New words are taken only between items, but a finished result may still
// wait in the output register while the next word is accepted.
// Reset leaves the whole bank at zero at once; there is no clearing pass.

`include "triggered_interval_timer_bank_assert.svh"

module triggered_interval_timer_bank #(
	parameter int unsigned NUM_CHANNELS = tib_pkg::NUM_CHANNELS_DEF
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	// input words
	input  wire logic                       item_valid,
	output      logic                       item_stall,
	input  wire logic                       mode,
	input  wire logic [tib_pkg::CH_W-1:0]   channel,
	input  wire logic [tib_pkg::TM_W-1:0]   trigger_mode,
	input  wire logic [tib_pkg::CNT_W-1:0]  period,
	input  wire logic                       level,
	// result words
	output      logic                       result_valid,
	input  wire logic                       result_stall,
	output      logic                       pulse,
	output      logic                       bad_period
);

	localparam int unsigned AW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
	localparam logic [AW-1:0] LAST_CH = AW'(NUM_CHANNELS - 1);

	tib_pkg::tib_state_t          state_q, state_d;

	// latched poll word
	logic [AW-1:0]                ch_q;
	logic [tib_pkg::TM_W-1:0]     tm_q;
	logic [tib_pkg::CNT_W-1:0]    per_q;
	logic                         lvl_q;

	// tick sweep
	logic [AW-1:0]                sweep_q;
	logic [AW-1:0]                tk_addr_s1;
	logic                         tk_vld_s1;

	// memory port
	logic                         mem_we;
	logic [AW-1:0]                mem_waddr;
	tib_pkg::tib_entry_t          mem_wdata;
	logic                         mem_re;
	logic [AW-1:0]                mem_raddr;
	tib_pkg::tib_entry_t          mem_rdata;

	// remainder unit
	tib_pkg::tib_div_req_t        div_req;
	tib_pkg::tib_div_rsp_t        div_rsp;

	// trigger evaluation
	tib_pkg::tib_pre_t            pre;
	tib_pkg::tib_entry_t          ev_entry;
	tib_pkg::tib_entry_t          pend_q;
	tib_pkg::tib_entry_t          tick_entry;
	logic                         active;
	logic                         per_zero;
	logic                         need_div;

	// result register
	logic                         res_pulse_q;
	logic                         res_bad_q;
	logic                         result_valid_q;
	logic                         pulse_q;
	logic                         bad_q;
	logic                         out_load;

	logic                         accept;
	logic                         in_range;

	assign accept   = item_valid && !item_stall;
	assign in_range = {3'b000, channel} < 9'(NUM_CHANNELS);

	tib_mem #(
		.NUM_CHANNELS(NUM_CHANNELS)
	) u_mem (
		.clk   (clk),
		.arst_n(arst_n),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	tib_rem u_rem (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (div_req),
		.rsp   (div_rsp)
	);

	// Trigger datapath on the entry just read. Inactive modes only record
	// mode and level; a zero period flags and keeps the count.
	always_comb begin
		pre      = tib_pkg::trig_pre(mem_rdata, tm_q, lvl_q);
		active   = !tm_q[2];
		per_zero = (per_q == '0);
		need_div = active && !per_zero && (pre.cnt >= per_q);
		ev_entry.tmode = tm_q;
		ev_entry.lvl   = lvl_q;
		if (active) begin
			ev_entry.cnt   = pre.cnt;
			ev_entry.armed = need_div ? 1'b0 : pre.armed;
		end else begin
			ev_entry.cnt   = mem_rdata.cnt;
			ev_entry.armed = mem_rdata.armed;
		end
	end

	// saturating increment for the sweep
	always_comb begin
		tick_entry = mem_rdata;
		if (mem_rdata.cnt != '1) tick_entry.cnt = mem_rdata.cnt + 1'b1;
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			tib_pkg::S_IDLE: begin
				if (accept) begin
					if (mode == tib_pkg::MODE_TICK) state_d = tib_pkg::S_TICK;
					else if (in_range)              state_d = tib_pkg::S_POLL_RD;
					else                            state_d = tib_pkg::S_DONE;
				end
			end
			tib_pkg::S_TICK: begin
				if (sweep_q == LAST_CH) state_d = tib_pkg::S_TICK_END;
			end
			tib_pkg::S_TICK_END:  state_d = tib_pkg::S_DONE;
			tib_pkg::S_POLL_RD:   state_d = tib_pkg::S_POLL_EVAL;
			tib_pkg::S_POLL_EVAL: begin
				state_d = need_div ? tib_pkg::S_POLL_DIV : tib_pkg::S_DONE;
			end
			tib_pkg::S_POLL_DIV: begin
				if (div_rsp.done) state_d = tib_pkg::S_DONE;
			end
			tib_pkg::S_DONE: begin
				if (out_load) state_d = tib_pkg::S_IDLE;
			end
			default: state_d = tib_pkg::S_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		item_stall       = (state_q != tib_pkg::S_IDLE);
		mem_re           = 1'b0;
		mem_raddr        = ch_q;
		mem_we           = 1'b0;
		mem_waddr        = ch_q;
		mem_wdata        = ev_entry;
		div_req.start    = 1'b0;
		div_req.dividend = pre.cnt;
		div_req.divisor  = per_q;
		out_load         = 1'b0;
		unique case (state_q)
			tib_pkg::S_IDLE: ;
			tib_pkg::S_TICK: begin
				mem_re    = 1'b1;
				mem_raddr = sweep_q;
				mem_we    = tk_vld_s1;
				mem_waddr = tk_addr_s1;
				mem_wdata = tick_entry;
			end
			tib_pkg::S_TICK_END: begin
				mem_we    = tk_vld_s1;
				mem_waddr = tk_addr_s1;
				mem_wdata = tick_entry;
			end
			tib_pkg::S_POLL_RD: begin
				mem_re = 1'b1;
			end
			tib_pkg::S_POLL_EVAL: begin
				mem_we        = !need_div;
				div_req.start = need_div;
			end
			tib_pkg::S_POLL_DIV: begin
				mem_we        = div_rsp.done;
				mem_wdata     = pend_q;
				mem_wdata.cnt = div_rsp.rem;
			end
			tib_pkg::S_DONE: begin
				out_load = !result_valid_q || !result_stall;
			end
			default: ;
		endcase
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			ch_q  <= AW'(channel);
			tm_q  <= trigger_mode;
			per_q <= period;
			lvl_q <= level;
		end
		tk_addr_s1 <= sweep_q;
		if (state_q == tib_pkg::S_POLL_EVAL) pend_q <= ev_entry;
		if (out_load) begin
			pulse_q <= res_pulse_q;
			bad_q   <= res_bad_q;
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= tib_pkg::S_IDLE;
			sweep_q        <= '0;
			tk_vld_s1      <= 1'b0;
			res_pulse_q    <= 1'b0;
			res_bad_q      <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			tk_vld_s1 <= (state_q == tib_pkg::S_TICK);
			if (accept) begin
				sweep_q     <= '0;
				res_pulse_q <= 1'b0;
				res_bad_q   <= 1'b0;
			end else if (state_q == tib_pkg::S_TICK) begin
				sweep_q <= sweep_q + 1'b1;
			end
			if (state_q == tib_pkg::S_POLL_EVAL) res_bad_q <= active && per_zero;
			if (state_q == tib_pkg::S_POLL_DIV && div_rsp.done) res_pulse_q <= 1'b1;
			if (out_load)           result_valid_q <= 1'b1;
			else if (!result_stall) result_valid_q <= 1'b0;
		end
	end

	assign result_valid = result_valid_q;
	assign pulse        = pulse_q;
	assign bad_period   = bad_q;

	`TIB_ASSERT(a_no_idle_write, clk, arst_n, mem_we |-> (state_q != tib_pkg::S_IDLE), "memory write while idle")
	`TIB_ASSERT(a_div_done_state, clk, arst_n, div_rsp.done |-> (state_q == tib_pkg::S_POLL_DIV), "remainder done outside poll")
	`TIB_ASSERT(a_rem_bound, clk, arst_n, div_rsp.done |-> (div_rsp.rem < per_q), "remainder not below period")
	`TIB_ASSERT(a_sweep_lag, clk, arst_n, ((state_q == tib_pkg::S_TICK) && tk_vld_s1) |-> (tk_addr_s1 + 1'b1 == sweep_q), "sweep write not one behind read")
	`TIB_NEVER(a_no_overwrite, clk, arst_n, out_load && result_valid_q && result_stall, "held result overwritten")

endmodule

`default_nettype wire

// ----- hw/rtl/tib_mem.sv -----
// Channel state memory: registered synchronous read, per-entry valid bits for reset.
`default_nettype none

module tib_mem #(
	parameter int unsigned NUM_CHANNELS = tib_pkg::NUM_CHANNELS_DEF
) (
	input  wire logic                                          clk,
	input  wire logic                                          arst_n,
	input  wire logic                                          we,
	input  wire logic [((NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1)-1:0] waddr,
	input  wire tib_pkg::tib_entry_t                           wdata,
	input  wire logic                                          re,
	input  wire logic [((NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1)-1:0] raddr,
	output      tib_pkg::tib_entry_t                           rdata
);

	tib_pkg::tib_entry_t       mem [0:NUM_CHANNELS-1];
	tib_pkg::tib_entry_t       rd_q;
	logic [NUM_CHANNELS-1:0]   vld_q;
	logic                      rd_vld_q;

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		if (re) rd_q <= mem[raddr];
	end

	// never-written entries read as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (we) vld_q[waddr] <= 1'b1;
			if (re) rd_vld_q <= vld_q[raddr];
		end
	end

	assign rdata = rd_vld_q ? rd_q : '0;

endmodule

`default_nettype wire

// ----- hw/rtl/tib_rem.sv -----
// Restoring remainder unit, one quotient bit per cycle.
`default_nettype none

module tib_rem (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire tib_pkg::tib_div_req_t req,
	output      tib_pkg::tib_div_rsp_t rsp
);

	localparam int unsigned W  = tib_pkg::CNT_W;
	localparam int unsigned CW = $clog2(W + 1);

	logic [W-1:0]  dv_q;
	logic [W-1:0]  den_q;
	logic [W-1:0]  rem_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;
	logic [W:0]    trial;
	logic [W:0]    diff;

	assign trial = {rem_q, dv_q[W-1]};
	assign diff  = trial - {1'b0, den_q};

	always_ff @(posedge clk) begin
		if (req.start) begin
			dv_q  <= req.dividend;
			den_q <= req.divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dv_q <= {dv_q[W-2:0], 1'b0};
			if (trial >= {1'b0, den_q}) rem_q <= diff[W-1:0];
			else                         rem_q <= trial[W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign rsp.busy = busy_q;
	assign rsp.done = done_q;
	assign rsp.rem  = rem_q;

endmodule

`default_nettype wire
